// ----- hw/rtl/dptm_pkg.sv -----
`default_nettype none

package dptm_pkg;

  // width of every reported measure and of the timeout register
  localparam int unsigned MEAS_W    = 24;
  localparam int unsigned TIMEOUT_W = 24;

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [PADDR_W-3:0]   REG_NO_SIGNAL_TIMEOUT = 1'd0;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET         = 24'd10000;

  // stream payload widths
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 152;
  localparam int unsigned OUT_USER_W = 1;

  typedef struct packed {
    logic [MEAS_W-1:0] length;
    logic [MEAS_W-1:0] period;
  } sensor_meas_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dptm_sensor.sv -----
`default_nettype none

module dptm_sensor #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           win_i,
  input  wire logic                           high_i,
  input  wire logic [dptm_pkg::TIMEOUT_W-1:0] timeout_i,
  output dptm_pkg::sensor_meas_t              meas_o
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > dptm_pkg::TIMEOUT_W) ?
                                  COUNT_WIDTH : dptm_pkg::TIMEOUT_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] len_q, len_d;
  logic [COUNT_WIDTH-1:0] idle_q, idle_d;
  logic [COUNT_WIDTH-1:0] per_q, per_d;
  logic                   len_flag_q, len_flag_d;
  logic                   per_flag_q, per_flag_d;
  dptm_pkg::sensor_meas_t meas_q, meas_d;

  logic [COUNT_WIDTH-1:0] idle_inc;
  logic [COUNT_WIDTH-1:0] per_base;
  logic                   timed_out;

  assign idle_inc  = (idle_q == CNT_MAX) ? idle_q : idle_q + COUNT_WIDTH'(1);
  assign timed_out = CMP_W'(idle_inc) >= CMP_W'(timeout_i);

  always_comb begin
    len_d      = len_q;
    idle_d     = idle_q;
    per_d      = per_q;
    len_flag_d = len_flag_q;
    per_flag_d = per_flag_q;
    meas_d     = meas_q;
    per_base   = per_q;
    if (win_i) begin
      // pulse length and no-signal timeout
      if (high_i) begin
        len_d = (len_q == CNT_MAX) ? len_q : len_q + COUNT_WIDTH'(1);
        if (!len_flag_q) begin
          len_flag_d = 1'b1;
          idle_d     = '0;
        end
      end else if (len_flag_q) begin
        meas_d.length = dptm_pkg::MEAS_W'(len_q);
        len_d         = '0;
        len_flag_d    = 1'b0;
      end else begin
        idle_d = idle_inc;
        if (timed_out) begin
          meas_d.length = '0;
          idle_d        = '0;
        end
      end
      // rising-edge period
      if (high_i) begin
        if (!per_flag_q) begin
          meas_d.period = dptm_pkg::MEAS_W'(per_q);
          per_base      = '0;
          per_flag_d    = 1'b1;
        end
      end else begin
        per_flag_d = 1'b0;
      end
      per_d = (per_base == CNT_MAX) ? per_base : per_base + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      idle_q     <= '0;
      per_q      <= '0;
      len_flag_q <= 1'b0;
      per_flag_q <= 1'b0;
      meas_q     <= '0;
    end else begin
      len_q      <= len_d;
      idle_q     <= idle_d;
      per_q      <= per_d;
      len_flag_q <= len_flag_d;
      per_flag_q <= per_flag_d;
      meas_q     <= meas_d;
    end
  end

  // next value, so the result register sees this window's update
  assign meas_o = meas_d;

endmodule

`default_nettype wire

// ----- hw/rtl/dptm_gap.sv -----
`default_nettype none

module dptm_gap #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        win_i,
  input  wire logic                        start_i,
  input  wire logic                        stop_i,
  output logic [dptm_pkg::MEAS_W-1:0]      gap_o
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0]        cnt_q, cnt_d;
  logic                          armed_q, armed_d;
  logic [dptm_pkg::MEAS_W-1:0]   gap_q, gap_d;
  logic [COUNT_WIDTH-1:0]        base;

  always_comb begin
    cnt_d   = cnt_q;
    armed_d = armed_q;
    gap_d   = gap_q;
    base    = cnt_q;
    if (win_i) begin
      if (start_i && !armed_q) begin
        base    = '0;
        armed_d = 1'b1;
      end
      // start and stop in the same window record zero
      if (stop_i && armed_d) begin
        gap_d   = dptm_pkg::MEAS_W'(base);
        armed_d = 1'b0;
      end
      cnt_d = (base == CNT_MAX) ? base : base + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      armed_q <= 1'b0;
      gap_q   <= '0;
    end else begin
      cnt_q   <= cnt_d;
      armed_q <= armed_d;
      gap_q   <= gap_d;
    end
  end

  assign gap_o = gap_d;

endmodule

`default_nettype wire

// ----- hw/rtl/dual_pulse_timing_meter.sv -----
`default_nettype none

// Dual pulse timing meter. Each request on the input stream is one sample of
// the mode, down and up pins; every SAMPLES_PER_WINDOW samples form a window
// in which a pin counts as high when more than half its samples were high.
// At each window close the block updates auto_on, the high-pulse length and
// rising-edge period of both sensors and the up-to-down and down-to-up gaps,
// all counted in windows and saturating at 2^COUNT_WIDTH-1 (reported as the
// low 24 bits). Every sample gives exactly one result, carrying window_done
// in tuser. A sample can be accepted every cycle and its result appears in the
// next cycle from the single output register. While that result waits for
// m_axis_tready the input is held off; when the result is taken in the same
// cycle a new sample arrives, both move with no gap. no_signal_timeout
// (address 0) sets how many idle windows pass before a zero length is
// recorded; write it only while the stream is idle.
module dual_pulse_timing_meter #(
  parameter int unsigned SAMPLES_PER_WINDOW = 2,
  parameter int unsigned COUNT_WIDTH        = 24
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // sample stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [0] mode_pin, [1] down_pin, [2] up_pin, [7:3] zero
  input  wire logic [dptm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [0] auto_on, [24:1] up_length, [48:25] down_length, [72:49] up_period,
  // [96:73] down_period, [120:97] up_to_down_gap, [144:121] down_to_up_gap,
  // [151:145] zero
  output logic [dptm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // [0] window_done
  output logic [dptm_pkg::OUT_USER_W-1:0]      m_axis_tuser,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dptm_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [dptm_pkg::PDATA_W-1:0]    pwdata,
  output logic [dptm_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);

  localparam int unsigned PW   = $clog2(SAMPLES_PER_WINDOW + 1);
  localparam int unsigned HALF = SAMPLES_PER_WINDOW / 2;
  localparam int unsigned MW   = dptm_pkg::MEAS_W;

  // configuration register
  logic [dptm_pkg::TIMEOUT_W-1:0] timeout_q;
  logic                           reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = paddr[dptm_pkg::PADDR_W-1:2] == dptm_pkg::REG_NO_SIGNAL_TIMEOUT;
  assign prdata  = reg_hit ? dptm_pkg::PDATA_W'(timeout_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= dptm_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      timeout_q <= pwdata[dptm_pkg::TIMEOUT_W-1:0];
    end
  end

  // window sampling
  logic          accept;
  logic          m_valid_q;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] tally_q [3];
  logic [PW-1:0] tally_d [3];
  logic [PW:0]   tally_sum [3];
  logic          qual [3];
  logic          win;
  logic          auto_q, auto_d;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign win = accept && (({1'b0, pos_q} + 1'b1) == (PW + 1)'(SAMPLES_PER_WINDOW));

  always_comb begin
    pos_d  = pos_q;
    auto_d = auto_q;
    for (int i = 0; i < 3; i++) begin
      tally_sum[i] = {1'b0, tally_q[i]} + {{PW{1'b0}}, s_axis_tdata[i]};
      qual[i]      = tally_sum[i] > (PW + 1)'(HALF);
      tally_d[i]   = tally_q[i];
    end
    if (win) begin
      pos_d  = '0;
      auto_d = qual[0];
      for (int i = 0; i < 3; i++) begin
        tally_d[i] = '0;
      end
    end else if (accept) begin
      pos_d = pos_q + PW'(1);
      for (int i = 0; i < 3; i++) begin
        tally_d[i] = tally_sum[i][PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      auto_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        tally_q[i] <= '0;
      end
    end else begin
      pos_q  <= pos_d;
      auto_q <= auto_d;
      for (int i = 0; i < 3; i++) begin
        tally_q[i] <= tally_d[i];
      end
    end
  end

  // measures; qual[1] is down, qual[2] is up
  dptm_pkg::sensor_meas_t up_meas, down_meas;
  logic [MW-1:0]          up_to_down, down_to_up;

  dptm_sensor #(.COUNT_WIDTH(COUNT_WIDTH)) u_up (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .win_i    (win),
    .high_i   (qual[2]),
    .timeout_i(timeout_q),
    .meas_o   (up_meas)
  );

  dptm_sensor #(.COUNT_WIDTH(COUNT_WIDTH)) u_down (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .win_i    (win),
    .high_i   (qual[1]),
    .timeout_i(timeout_q),
    .meas_o   (down_meas)
  );

  dptm_gap #(.COUNT_WIDTH(COUNT_WIDTH)) u_gap_up_down (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .win_i  (win),
    .start_i(qual[2]),
    .stop_i (qual[1]),
    .gap_o  (up_to_down)
  );

  dptm_gap #(.COUNT_WIDTH(COUNT_WIDTH)) u_gap_down_up (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .win_i  (win),
    .start_i(qual[1]),
    .stop_i (qual[2]),
    .gap_o  (down_to_up)
  );

  // result register
  logic [dptm_pkg::OUT_DATA_W-1:0] data_q;
  logic                            done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      done_q <= win;
      data_q <= dptm_pkg::OUT_DATA_W'({down_to_up, up_to_down, down_meas.period,
                                       up_meas.period, down_meas.length,
                                       up_meas.length, auto_d});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = done_q;

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_valid_q)
    else $error("accepted sample produced no result");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, pos_q} < (PW + 1)'(SAMPLES_PER_WINDOW)))
    else $error("sample position beyond window");

  a_window_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win |=> (pos_q == '0) && (tally_q[0] == '0) && (tally_q[1] == '0)
            && (tally_q[2] == '0))
    else $error("window close did not clear counters");

  a_tally_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tally_q[0] <= pos_q) && (tally_q[1] <= pos_q) && (tally_q[2] <= pos_q))
    else $error("ones tally exceeds samples taken");
`endif

endmodule

`default_nettype wire
